### sv/mtp_pkg.sv
package mtp_pkg;

	localparam int unsigned CHAR_W   = 8;
	localparam int unsigned MAC_W    = 48;
	localparam int unsigned GROUP_W  = 16;
	localparam int unsigned CNT_W    = 3;
	localparam int unsigned GCOUNT_W = 4;
	// mac_addr + status + addr_format, padded up to whole bytes
	localparam int unsigned OUT_BITS = MAC_W + 1 + 2;
	localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
	localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3A;
	localparam logic [CHAR_W-1:0] CH_HYPHEN = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_0      = 8'h30;
	localparam logic [CHAR_W-1:0] CH_9      = 8'h39;
	localparam logic [CHAR_W-1:0] CH_LA     = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LF     = 8'h66;
	localparam logic [CHAR_W-1:0] CH_UA     = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UF     = 8'h46;

	localparam logic [CNT_W-1:0]    CNT_MAX       = '1;
	localparam logic [CNT_W-1:0]    BYTE_SEP_MAX  = 3'd5;
	localparam logic [CNT_W-1:0]    SHORT_SEP_MAX = 3'd2;
	localparam logic [CNT_W-1:0]    BYTE_LEN_MAX  = 3'd2;
	localparam logic [CNT_W-1:0]    SHORT_LEN_MAX = 3'd4;
	localparam logic [GCOUNT_W-1:0] BYTE_GROUPS   = 4'd6;
	localparam logic [GCOUNT_W-1:0] SHORT_GROUPS  = 4'd3;

	typedef enum logic [1:0] {
		FMT_COLON  = 2'd0,
		FMT_HYPHEN = 2'd1,
		FMT_SHORT  = 2'd2,
		FMT_NONE   = 2'd3
	} fmt_t;

	typedef enum logic {
		ST_OK      = 1'b0,
		ST_INVALID = 1'b1
	} status_t;

	typedef struct packed {
		logic               colon_alive;
		logic               hyphen_alive;
		logic               short_alive;
		logic               after_hex;
		logic [CNT_W-1:0]   sep_count;
		logic [CNT_W-1:0]   group_len;
		logic [GROUP_W-1:0] group_val;
		logic [MAC_W-1:0]   byte_acc;
		logic [MAC_W-1:0]   word_acc;
		logic               ended;
	} parse_state_t;

	localparam parse_state_t STATE_RESET = '{
		colon_alive:  1'b1,
		hyphen_alive: 1'b1,
		short_alive:  1'b1,
		after_hex:    1'b0,
		sep_count:    '0,
		group_len:    '0,
		group_val:    '0,
		byte_acc:     '0,
		word_acc:     '0,
		ended:        1'b0
	};

	typedef struct packed {
		logic [MAC_W-1:0] mac_addr;
		status_t          status;
		fmt_t             addr_format;
	} result_t;

	typedef struct packed {
		logic       valid;
		logic [3:0] nibble;
	} hex_t;

	function automatic hex_t hex_decode(input logic [CHAR_W-1:0] c);
		hex_t h;
		h.valid  = 1'b1;
		h.nibble = '0;
		if (c >= CH_0 && c <= CH_9) begin
			h.nibble = 4'(c - CH_0);
		end else if (c >= CH_LA && c <= CH_LF) begin
			h.nibble = 4'(c - CH_LA + 8'd10);
		end else if (c >= CH_UA && c <= CH_UF) begin
			h.nibble = 4'(c - CH_UA + 8'd10);
		end else begin
			h.valid = 1'b0;
		end
		return h;
	endfunction

endpackage

### sv/mtp_step.sv
// One character through the three format checks, plus the end-of-string verdict.
module mtp_step (
	input  mtp_pkg::parse_state_t          cur,
	input  logic [mtp_pkg::CHAR_W-1:0]     ch,
	output mtp_pkg::parse_state_t          nxt,
	output mtp_pkg::result_t               res
);

	mtp_pkg::hex_t                    hx;
	logic                             is_colon;
	logic                             is_hyphen;
	logic [mtp_pkg::CNT_W-1:0]        sep_inc;
	logic [mtp_pkg::CNT_W-1:0]        len_inc;
	logic [mtp_pkg::GCOUNT_W-1:0]     groups;

	assign hx        = mtp_pkg::hex_decode(ch);
	assign is_colon  = cur.after_hex && (ch == mtp_pkg::CH_COLON);
	assign is_hyphen = cur.after_hex && (ch == mtp_pkg::CH_HYPHEN);
	assign sep_inc   = (cur.sep_count == mtp_pkg::CNT_MAX) ? cur.sep_count
		: cur.sep_count + 1'b1;
	assign len_inc   = (cur.group_len == mtp_pkg::CNT_MAX) ? cur.group_len
		: cur.group_len + 1'b1;

	always_comb begin
		nxt = cur;
		if (!cur.ended) begin
			if (ch == mtp_pkg::CH_NUL) begin
				nxt.ended = 1'b1;
			end else if (is_colon || is_hyphen) begin
				nxt.byte_acc  = {cur.byte_acc[mtp_pkg::MAC_W-9:0], cur.group_val[7:0]};
				nxt.word_acc  = {cur.word_acc[mtp_pkg::MAC_W-mtp_pkg::GROUP_W-1:0],
					cur.group_val};
				nxt.group_val = '0;
				nxt.group_len = '0;
				nxt.after_hex = 1'b0;
				nxt.sep_count = sep_inc;
				if (is_colon) begin
					nxt.hyphen_alive = 1'b0;
					nxt.short_alive  = 1'b0;
				end else begin
					nxt.colon_alive = 1'b0;
				end
				if (sep_inc > mtp_pkg::BYTE_SEP_MAX) begin
					nxt.colon_alive  = 1'b0;
					nxt.hyphen_alive = 1'b0;
				end
				if (sep_inc > mtp_pkg::SHORT_SEP_MAX) begin
					nxt.short_alive = 1'b0;
				end
			end else if (hx.valid) begin
				nxt.group_len = len_inc;
				nxt.group_val = {cur.group_val[mtp_pkg::GROUP_W-5:0], hx.nibble};
				nxt.after_hex = 1'b1;
				if (len_inc > mtp_pkg::BYTE_LEN_MAX) begin
					nxt.colon_alive  = 1'b0;
					nxt.hyphen_alive = 1'b0;
				end
				if (len_inc > mtp_pkg::SHORT_LEN_MAX) begin
					nxt.short_alive = 1'b0;
				end
			end else begin
				nxt.colon_alive  = 1'b0;
				nxt.hyphen_alive = 1'b0;
				nxt.short_alive  = 1'b0;
			end
		end
	end

	assign groups = {1'b0, nxt.sep_count} + {{(mtp_pkg::GCOUNT_W-1){1'b0}}, nxt.after_hex};

	always_comb begin
		res.mac_addr    = '0;
		res.status      = mtp_pkg::ST_INVALID;
		res.addr_format = mtp_pkg::FMT_NONE;
		priority if (nxt.colon_alive || nxt.hyphen_alive) begin
			res.addr_format = nxt.colon_alive ? mtp_pkg::FMT_COLON : mtp_pkg::FMT_HYPHEN;
			if (groups == mtp_pkg::BYTE_GROUPS) begin
				res.status   = mtp_pkg::ST_OK;
				res.mac_addr = {nxt.byte_acc[mtp_pkg::MAC_W-9:0], nxt.group_val[7:0]};
			end
		end else if (nxt.short_alive) begin
			res.addr_format = mtp_pkg::FMT_SHORT;
			if (groups == mtp_pkg::SHORT_GROUPS) begin
				res.status   = mtp_pkg::ST_OK;
				res.mac_addr = {nxt.word_acc[mtp_pkg::MAC_W-mtp_pkg::GROUP_W-1:0],
					nxt.group_val};
			end
		end else begin
			res.addr_format = mtp_pkg::FMT_NONE;
		end
	end

endmodule

### sv/mac_address_text_parser.sv
// MAC address text parser: feed the address text one ASCII character per beat on the
// slave side and mark the final character with s_tlast; one result beat follows on the
// master side with the 48-bit address (first byte most significant), a status (0 valid,
// 1 invalid) and the format that decided it (0 xx:xx:xx:xx:xx:xx, 1 xx-xx-xx-xx-xx-xx,
// 2 xxxx-xxxx-xxxx, 3 none). A NUL ends the text; characters after it up to the tlast
// beat are ignored. The block takes one character every cycle with no gaps between
// strings, except that a final character waits while the result slot is full; the
// result goes through the input register, then the parse state / result register. The
// only stall comes from the master side holding off a result. The parse state returns to
// its reset value after every result.
module mac_address_text_parser (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [mtp_pkg::CHAR_W-1:0]  s_tdata,   // [7:0] ch
	input  logic                        s_tlast,   // last
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [mtp_pkg::OUT_W-1:0]   m_tdata    // [47:0] mac_addr, [48] status,
	                                               // [50:49] addr_format, rest zero
);

	// input register
	logic                         vld_s1;
	logic [mtp_pkg::CHAR_W-1:0]   ch_s1;
	logic                         last_s1;

	// parse state and result register
	mtp_pkg::parse_state_t        st_q;
	mtp_pkg::parse_state_t        st_nxt;
	mtp_pkg::result_t             res_nxt;
	mtp_pkg::result_t             res_q;
	logic                         res_vld_q;

	logic                         out_free;
	logic                         adv_s1;

	// a result beat frees up when taken; non-final characters never need the slot
	assign out_free = !res_vld_q || m_tready;
	assign adv_s1   = vld_s1 && (!last_s1 || out_free);
	assign s_tready = !vld_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			ch_s1   <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	mtp_step u_step (
		.cur (st_q),
		.ch  (ch_s1),
		.nxt (st_nxt),
		.res (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= mtp_pkg::STATE_RESET;
		end else if (adv_s1) begin
			st_q <= last_s1 ? mtp_pkg::STATE_RESET : st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			res_vld_q <= 1'b1;
		end else if (m_tready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			res_q <= res_nxt;
		end
	end

	assign m_tvalid = res_vld_q;
	assign m_tdata  = {{(mtp_pkg::OUT_W - mtp_pkg::OUT_BITS){1'b0}},
		res_q.addr_format, res_q.status, res_q.mac_addr};

`ifndef SYNTHESIS
	// an invalid result never carries an address
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld_q && res_q.status == mtp_pkg::ST_INVALID |-> res_q.mac_addr == '0)
		else $error("invalid result with nonzero address");

	// a valid result always names a format
	a_ok_has_fmt: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld_q && res_q.status == mtp_pkg::ST_OK |-> res_q.addr_format != mtp_pkg::FMT_NONE)
		else $error("valid result without a format");

	// a final character always produces a result beat next cycle
	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && last_s1 |=> res_vld_q)
		else $error("result missing after final character");

	// parse state is back at reset after each string
	a_state_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && last_s1 |=> st_q == mtp_pkg::STATE_RESET)
		else $error("parse state not cleared after result");

	// a pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld_q && !m_tready |-> !(adv_s1 && last_s1))
		else $error("result overwritten while stalled");
`endif

endmodule
